/* hdl/gf2_matrix_multiply_assert.svh */
// assertion macros for the gf2 matrix multiplier
// used by gf2_matrix_multiply.sv; expects aclk and aresetn in scope
`ifndef GF2_MATRIX_MULTIPLY_ASSERT_SVH
`define GF2_MATRIX_MULTIPLY_ASSERT_SVH

// consequent checked in the same cycle
`define GF2MM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define GF2MM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/gf2mm_pkg.sv */
// shared types, constants and helpers for the gf2 matrix multiplier
// no dependencies
`default_nettype none

package gf2mm_pkg;

    localparam int DEF_MAX_DIM = 64;

    localparam int DATA_W    = 64;   // row bits
    localparam int ROW_W     = 6;    // row index
    localparam int DIM_W     = 7;    // size registers
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 72;   // row index + row bits, padded to bytes
    localparam int PAD_W     = TDATA_W - ROW_W - DATA_W;

    localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LREAD,
        ST_WALK,
        ST_OUT
    } state_t;

    // ones in the low n bits
    function automatic logic [DATA_W-1:0] low_mask(input logic [DIM_W-1:0] n);
        logic [DATA_W-1:0] m;
        for (int j = 0; j < DATA_W; j++) begin
            m[j] = (DIM_W'(j) < n);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* hdl/gf2mm_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module gf2mm_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/gf2_matrix_multiply.sv */
// Multiplies two bit matrices over GF(2). Rows of the left and right matrix are
// loaded one per transaction into two row RAMs; a compute transaction returns
// one product row, the XOR of the right rows selected by the set bits of the
// chosen left row, masked to right_cols. A compute first reads the left row,
// then walks the right rows up to inner_size, with an inner_size above MAX_DIM
// counting as MAX_DIM, since the right RAM has a single read port and the left
// row's bits are shifted out one per cycle, and then hands the row to the
// result register. A compute with a row index not below left_rows skips the
// reads and returns zero bits with the bad flag set. Either kind of compute
// waits in its output state while the previous result has not yet been taken.
// The result register lets a finished row wait while loads continue. Depends on
// gf2mm_pkg, gf2mm_ram and the assertion header.
`default_nettype none

`include "gf2_matrix_multiply_assert.svh"

module gf2_matrix_multiply
    import gf2mm_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    input  wire logic [TDATA_W-1:0]   s_tdata,   // row_index[5:0], row_bits[69:6]
    input  wire logic [OP_W-1:0]      s_tuser,   // opcode[1:0]
    // result stream
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [TDATA_W-1:0]   m_tdata,   // result_row[5:0], result_bits[69:6]
    output      logic                 m_tuser,   // bad_index[0]
    // configuration writes
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data
);

    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int KW     = $clog2(MAX_DIM + 1);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]  left_rows_reg, inner_size_reg, right_cols_reg;
    logic [KW-1:0]     k_reg, k_next, k_inc;
    logic [DATA_W-1:0] sel_reg, sel_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              bad_reg, bad_next;
    logic              m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]  m_row_reg, m_row_next;
    logic [DATA_W-1:0] m_bits_reg, m_bits_next;
    logic              m_bad_reg, m_bad_next;

    logic [DIM_W-1:0]  nl, nk, nc;
    logic              s_fire;
    logic [OP_W-1:0]   s_op;
    logic [ROW_W-1:0]  s_row;
    logic [DATA_W-1:0] s_bits;
    logic              row_ok_l, row_ok_r, last_k, out_free;

    logic              left_wr_en, right_wr_en, left_rd_en, right_rd_en;
    logic [ADDR_W-1:0] right_rd_addr;
    logic [DATA_W-1:0] left_rd_data, right_rd_data;

    assign s_op   = s_tuser;
    assign s_row  = s_tdata[ROW_W-1:0];
    assign s_bits = s_tdata[ROW_W+DATA_W-1:ROW_W];
    assign s_fire = s_tvalid && s_tready;

    // sizes above the store depth saturate
    assign nl = (left_rows_reg  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : left_rows_reg;
    assign nk = (inner_size_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : inner_size_reg;
    assign nc = (right_cols_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : right_cols_reg;

    assign row_ok_l = DIM_W'(s_row) < nl;
    assign row_ok_r = DIM_W'(s_row) < nk;
    assign k_inc    = k_reg + KW'(1);
    assign last_k   = (DIM_W'(k_reg) + DIM_W'(1)) == nk;
    assign out_free = !m_valid_reg || m_tready;

    assign cfg_ready = 1'b1;

    gf2mm_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (MAX_DIM),
        .ADDR_W (ADDR_W)
    ) u_left_ram (
        .aclk    (aclk),
        .wr_en   (left_wr_en),
        .wr_addr (s_row[ADDR_W-1:0]),
        .wr_data (s_bits),
        .rd_en   (left_rd_en),
        .rd_addr (s_row[ADDR_W-1:0]),
        .rd_data (left_rd_data)
    );

    gf2mm_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (MAX_DIM),
        .ADDR_W (ADDR_W)
    ) u_right_ram (
        .aclk    (aclk),
        .wr_en   (right_wr_en),
        .wr_addr (s_row[ADDR_W-1:0]),
        .wr_data (s_bits),
        .rd_en   (right_rd_en),
        .rd_addr (right_rd_addr),
        .rd_data (right_rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_op == OP_COMPUTE) begin
                    state_next = row_ok_l ? ST_LREAD : ST_OUT;
                end
            end
            ST_LREAD: begin
                state_next = (nk == '0) ? ST_OUT : ST_WALK;
            end
            ST_WALK: begin
                if (last_k) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_tready      = 1'b0;
        left_wr_en    = 1'b0;
        right_wr_en   = 1'b0;
        left_rd_en    = 1'b0;
        right_rd_en   = 1'b0;
        right_rd_addr = k_inc[ADDR_W-1:0];
        k_next        = k_reg;
        sel_next      = sel_reg;
        acc_next      = acc_reg;
        row_next      = row_reg;
        bad_next      = bad_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_row_next    = m_row_reg;
        m_bits_next   = m_bits_reg;
        m_bad_next    = m_bad_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                left_wr_en  = s_tvalid && s_op == OP_LOAD_LEFT  && row_ok_l;
                right_wr_en = s_tvalid && s_op == OP_LOAD_RIGHT && row_ok_r;
                left_rd_en  = s_tvalid && s_op == OP_COMPUTE;
                if (s_fire && s_op == OP_COMPUTE) begin
                    row_next = s_row;
                    bad_next = !row_ok_l;
                    acc_next = '0;
                end
            end
            ST_LREAD: begin
                right_rd_en   = 1'b1;
                right_rd_addr = '0;
                sel_next      = left_rd_data;
                k_next        = '0;
            end
            ST_WALK: begin
                // right row k is on the read data, row k+1 is being fetched
                right_rd_en = 1'b1;
                if (sel_reg[0]) begin
                    acc_next = acc_reg ^ right_rd_data;
                end
                sel_next = sel_reg >> 1;
                k_next   = k_inc;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_row_next   = row_reg;
                    m_bits_next  = acc_reg & low_mask(nc);
                    m_bad_next   = bad_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            left_rows_reg  <= DIM_RESET;
            inner_size_reg <= DIM_RESET;
            right_cols_reg <= DIM_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_LEFT_ROWS:  left_rows_reg  <= cfg_data;
                    REG_INNER_SIZE: inner_size_reg <= cfg_data;
                    REG_RIGHT_COLS: right_cols_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        sel_reg    <= sel_next;
        acc_reg    <= acc_next;
        row_reg    <= row_next;
        bad_reg    <= bad_next;
        m_row_reg  <= m_row_next;
        m_bits_reg <= m_bits_next;
        m_bad_reg  <= m_bad_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_bits_reg, m_row_reg};
    assign m_tuser  = m_bad_reg;

    `GF2MM_ASSERT_SAME(a_bad_gives_zero, m_valid_reg && m_bad_reg, m_bits_reg == '0,
        "bad index result carries nonzero bits")
    `GF2MM_ASSERT_SAME(a_walk_in_range, state_reg == ST_WALK, DIM_W'(k_reg) < nk,
        "walk index beyond inner size")
    `GF2MM_ASSERT_NEXT(a_good_compute_reads, s_fire && s_op == OP_COMPUTE && row_ok_l,
        state_reg == ST_LREAD, "valid compute did not start a left row read")
    `GF2MM_ASSERT_NEXT(a_result_loaded, state_reg == ST_OUT && out_free,
        m_valid_reg && state_reg == ST_IDLE, "finished row not presented")

endmodule

`default_nettype wire

/* tb/gf2_matrix_multiply_tb.sv */
// self-checking testbench for gf2_matrix_multiply: row loads, product row computes, size writes
// holds its own GF(2) row predictor and compares every result transaction in order
// depends on gf2mm_pkg and the gf2_matrix_multiply rtl
`default_nettype none

module gf2_matrix_multiply_tb
    import gf2mm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_OPS    = 60;
    localparam int SETTLE_CYC   = 100;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int MAX_REPORTS  = 10;
    localparam logic [OP_W-1:0]      OP_NONE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] bits;
    } mat_op_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [DATA_W-1:0] bits;
        logic              bad;
    } product_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;

    gf2_matrix_multiply dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // predictor state
    logic [DATA_W-1:0] left_rows_mem  [64];
    logic [DATA_W-1:0] right_rows_mem [64];
    logic [DIM_W-1:0]  size_left_rows  = DIM_RESET;
    logic [DIM_W-1:0]  size_inner      = DIM_RESET;
    logic [DIM_W-1:0]  size_right_cols = DIM_RESET;

    mat_op_t  pending_ops[$];
    product_t expected_products[$];
    int       ops_queued      = 0;
    int       ops_accepted    = 0;
    int       mismatches      = 0;
    int       stall_cycles    = 0;
    int       holds_requested = 0;
    int       holds_served    = 0;
    bit       src_gaps_on     = 1'b1;
    bit       snk_gaps_on     = 1'b1;

    function automatic int sat_dim(input logic [DIM_W-1:0] v);
        return (v > 7'd64) ? 64 : int'(v);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] gf2_product_row(input logic [ROW_W-1:0] r);
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] sel;
        int nk;
        int nc;
        nk  = sat_dim(size_inner);
        nc  = sat_dim(size_right_cols);
        sel = left_rows_mem[r];
        acc = '0;
        for (int k = 0; k < nk; k++) begin
            if (sel[k]) acc ^= right_rows_mem[k];
        end
        for (int j = nc; j < DATA_W; j++) begin
            acc[j] = 1'b0;
        end
        return acc;
    endfunction

    task automatic predict_op(input mat_op_t op);
        product_t p;
        int nl;
        int nk;
        nl = sat_dim(size_left_rows);
        nk = sat_dim(size_inner);
        case (op.opcode)
            OP_LOAD_LEFT: begin
                if (int'(op.row) < nl) left_rows_mem[op.row] = op.bits;
            end
            OP_LOAD_RIGHT: begin
                if (int'(op.row) < nk) right_rows_mem[op.row] = op.bits;
            end
            OP_COMPUTE: begin
                p.row = op.row;
                p.bad = (int'(op.row) >= nl);
                p.bits = p.bad ? '0 : gf2_product_row(op.row);
                expected_products.push_back(p);
            end
            default: ;
        endcase
    endtask

    // input driver
    mat_op_t offered;
    int      src_wait = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_op(offered);
                ops_accepted++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transaction
            end else if (src_wait > 0) begin
                src_wait--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                offered = pending_ops.pop_front();
                s_tuser  <= offered.opcode;
                s_tdata  <= {{PAD_W{1'b0}}, offered.bits, offered.row};
                s_tvalid <= 1'b1;
                if (src_gaps_on) src_wait = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    int snk_wait = 0;

    always @(posedge aclk) begin
        product_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_products.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: row %0d bits %h bad %b",
                                 m_tdata[ROW_W-1:0], m_tdata[ROW_W +: DATA_W], m_tuser);
                end else begin
                    want = expected_products.pop_front();
                    if (m_tdata[ROW_W-1:0] !== want.row ||
                        m_tdata[ROW_W +: DATA_W] !== want.bits ||
                        m_tuser !== want.bad) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: exp row %0d bits %h bad %b, got row %0d bits %h bad %b",
                                     want.row, want.bits, want.bad, m_tdata[ROW_W-1:0],
                                     m_tdata[ROW_W +: DATA_W], m_tuser);
                    end
                end
            end
            if (holds_served != holds_requested) begin
                holds_served++;
                snk_wait = LONG_HOLD;
            end
            if (snk_wait > 0) begin
                snk_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (snk_gaps_on && $urandom_range(0, 99) < 25) snk_wait = pick_gap();
            end
        end
    end

    // count cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic queue_op(input logic [OP_W-1:0] opc, input int row,
                            input logic [DATA_W-1:0] bits);
        mat_op_t op;
        op.opcode = opc;
        op.row    = ROW_W'(row);
        op.bits   = bits;
        pending_ops.push_back(op);
        ops_queued++;
    endtask

    function automatic logic [DATA_W-1:0] rand_row_bits();
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v = v & {$urandom, $urandom};   // sparse rows
            default: ;
        endcase
        return v;
    endfunction

    // row index mostly inside the size in use, sometimes anywhere
    function automatic int pick_row(input int limit);
        if (limit > 0 && $urandom_range(0, 99) < 80) return $urandom_range(0, limit - 1);
        return $urandom_range(0, 63);
    endfunction

    task automatic queue_random_op();
        int r;
        int nl;
        int nk;
        nl = sat_dim(size_left_rows);
        nk = sat_dim(size_inner);
        r  = $urandom_range(0, 99);
        if (r < 45)
            queue_op(OP_COMPUTE, pick_row(nl), rand_row_bits());
        else if (r < 70)
            queue_op(OP_LOAD_LEFT, pick_row(nl), rand_row_bits());
        else if (r < 95)
            queue_op(OP_LOAD_RIGHT, pick_row(nk), rand_row_bits());
        else
            queue_op(OP_NONE, $urandom_range(0, 63), rand_row_bits());
    endtask

    task automatic wait_idle();
        while (ops_accepted != ops_queued || expected_products.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_size_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIM_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LEFT_ROWS:  size_left_rows  = DIM_W'(value);
            REG_INNER_SIZE: size_inner      = DIM_W'(value);
            REG_RIGHT_COLS: size_right_cols = DIM_W'(value);
            default: ;
        endcase
    endtask

    initial begin : stimulus
        int lr;
        int ks;
        int rc;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill both row stores at the reset sizes so no unwritten row is ever read
        for (int i = 0; i < 64; i++) begin
            queue_op(OP_LOAD_LEFT, i, rand_row_bits());
            queue_op(OP_LOAD_RIGHT, i, rand_row_bits());
        end

        // directed: full, empty and single-bit left rows, ignored opcode
        queue_op(OP_LOAD_LEFT, 0, '1);
        queue_op(OP_LOAD_LEFT, 1, '0);
        queue_op(OP_LOAD_LEFT, 2, 64'h8000_0000_0000_0000);
        queue_op(OP_LOAD_RIGHT, 0, 64'haaaa_aaaa_aaaa_aaaa);
        queue_op(OP_LOAD_RIGHT, 63, '1);
        queue_op(OP_COMPUTE, 0, '0);
        queue_op(OP_COMPUTE, 1, '1);
        queue_op(OP_COMPUTE, 2, '0);
        queue_op(OP_COMPUTE, 63, '1);
        queue_op(OP_NONE, 2, '1);
        queue_op(OP_COMPUTE, 2, '0);
        queue_op(OP_LOAD_LEFT, 63, '0);
        queue_op(OP_COMPUTE, 63, '0);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin lr = 1;   ks = 1;   rc = 1;   end
                1: begin lr = 0;   ks = 0;   rc = 0;   end
                2: begin lr = 127; ks = 127; rc = 127; end
                3: begin lr = 64;  ks = 64;  rc = 64;  end
                4: begin lr = 16;  ks = 8;   rc = 32;  end
                5: begin lr = 64;  ks = 1;   rc = 64;  end
                6: begin lr = 40;  ks = 64;  rc = 1;   end
                default: begin
                    lr = $urandom_range(1, 64);
                    ks = $urandom_range(1, 64);
                    rc = $urandom_range(1, 64);
                end
            endcase
            write_size_reg(REG_LEFT_ROWS, lr);
            write_size_reg(REG_INNER_SIZE, ks);
            write_size_reg(REG_RIGHT_COLS, rc);
            if (p % 4 == 1) write_size_reg(REG_UNUSED, $urandom_range(0, 127));

            // some phases run back to back on both sides
            src_gaps_on = (p % 3 != 2);
            snk_gaps_on = (p % 3 != 2);
            if (p == 3) holds_requested++;

            for (int i = 0; i < PHASE_OPS; i++) queue_random_op();
            wait_idle();
        end

        if (mismatches == 0 && expected_products.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/gf2mm_pkg.sv
hdl/gf2mm_ram.sv
hdl/gf2_matrix_multiply.sv
tb/gf2_matrix_multiply_tb.sv
